// ===== rtl/core/rv32m_pkg.sv =====
// Shared types and constants for the multiply/divide unit.
package rv32m_pkg;

  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned OpWidth   = 3;
  localparam int unsigned DestWidth = 5;

  typedef enum logic [OpWidth-1:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } rv32m_op_e;

  // Control that travels down the cell chain with each transaction.
  typedef struct packed {
    logic                 valid;
    rv32m_op_e            op;
    logic                 is_div;
    logic                 neg_res;
    logic [DestWidth-1:0] dest;
  } rv32m_ctl_t;

endpackage

// ===== rtl/core/rv32m_req_if.sv =====
// Request channel interface.
interface rv32m_req_if
  import rv32m_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) ();
  logic                 valid;
  logic                 ready;
  logic [OpWidth-1:0]   req_type;
  logic [DataWidth-1:0] operand_a;
  logic [DataWidth-1:0] operand_b;
  logic [DestWidth-1:0] dest_index;

  modport source (output valid, req_type, operand_a, operand_b, dest_index, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, dest_index, output ready);
endinterface

// ===== rtl/core/rv32m_rsp_if.sv =====
// Result channel interface.
interface rv32m_rsp_if
  import rv32m_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) ();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] result_value;
  logic [DestWidth-1:0] result_dest;

  modport source (output valid, result_value, result_dest, input ready);
  modport sink   (input valid, result_value, result_dest, output ready);
endinterface

// ===== rtl/core/rv32m_cell.sv =====
// One chain cell: a restoring divide step or a multiply partial-product add.
module rv32m_cell
  import rv32m_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault,
  parameter int unsigned Index     = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  rv32m_ctl_t             ctl_i,
  input  logic [2*DataWidth-1:0] acc_i,
  input  logic [DataWidth-1:0]   x_i,
  input  logic [DataWidth-1:0]   y_i,
  output rv32m_ctl_t             ctl_o,
  output logic [2*DataWidth-1:0] acc_o,
  output logic [DataWidth-1:0]   x_o,
  output logic [DataWidth-1:0]   y_o
);
  // Divide: acc holds {remainder, quotient-so-far}, y is the divisor magnitude.
  // Multiply: acc is the running product, x the multiplicand magnitude, y the multiplier.
  logic [2*DataWidth-1:0] acc_d, sh;
  logic [DataWidth:0]     diff;
  logic [2*DataWidth-1:0] addend;

  always_comb begin
    sh     = {acc_i[2*DataWidth-2:0], 1'b0};
    diff   = {1'b0, sh[2*DataWidth-1:DataWidth]} - {1'b0, y_i};
    addend = {{DataWidth{1'b0}}, x_i} << Index;
    if (ctl_i.is_div) begin
      if (!diff[DataWidth]) begin
        acc_d = {diff[DataWidth-1:0], sh[DataWidth-1:1], 1'b1};
      end else begin
        acc_d = sh;
      end
    end else begin
      acc_d = y_i[Index] ? acc_i + addend : acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_o <= acc_d;
      x_o   <= x_i;
      y_o   <= y_i;
      ctl_o <= ctl_i;
    end
  end
endmodule

// ===== rtl/core/rv32m_chain.sv =====
// Row of cells that carry each transaction through one bit per stage.
module rv32m_chain
  import rv32m_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  rv32m_ctl_t             ctl_i,
  input  logic [2*DataWidth-1:0] acc_i,
  input  logic [DataWidth-1:0]   x_i,
  input  logic [DataWidth-1:0]   y_i,
  output rv32m_ctl_t             ctl_o,
  output logic [2*DataWidth-1:0] acc_o
);
  rv32m_ctl_t             ctl_w [DataWidth+1];
  rv32m_ctl_t             ctl_r [DataWidth];
  logic [2*DataWidth-1:0] acc_w [DataWidth+1];
  logic [DataWidth-1:0]   x_w   [DataWidth+1];
  logic [DataWidth-1:0]   y_w   [DataWidth+1];
  logic [DataWidth-1:0]   vld_q;

  assign ctl_w[0] = ctl_i;
  assign acc_w[0] = acc_i;
  assign x_w[0]   = x_i;
  assign y_w[0]   = y_i;

  for (genvar g = 0; g < DataWidth; g++) begin : g_cell
    rv32m_cell #(.DataWidth(DataWidth), .Index(g)) u_cell (
      .clk_i, .en_i,
      .ctl_i(ctl_w[g]), .acc_i(acc_w[g]), .x_i(x_w[g]), .y_i(y_w[g]),
      .ctl_o(ctl_r[g]), .acc_o(acc_w[g+1]), .x_o(x_w[g+1]), .y_o(y_w[g+1])
    );
    // Valid bits need reset; the payload does not.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= ctl_w[g].valid;
      end
    end
    always_comb begin
      ctl_w[g+1]       = ctl_r[g];
      ctl_w[g+1].valid = vld_q[g];
    end
  end

  assign ctl_o = ctl_w[DataWidth];
  assign acc_o = acc_w[DataWidth];
endmodule

// ===== rtl/core/rv32m_multiply_divide_unit_top.sv =====
// Top level of the multiply/divide unit.
// Fully pipelined: one transaction accepted per cycle. The pipe is the chain of DataWidth
// cells, each resolving one multiplier or quotient bit, plus an operand-conditioning stage
// and a sign-fixup output register.
// The whole pipe stalls while the output register holds an untaken result.
module rv32m_multiply_divide_unit_top
  import rv32m_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input logic           clk_i,
  input logic           rst_ni,
  rv32m_req_if.sink     req,
  rv32m_rsp_if.source   rsp
);
  localparam logic [DataWidth-1:0] AllOnes = '1;
  localparam logic [DataWidth-1:0] MinNeg  = {1'b1, {(DataWidth-1){1'b0}}};

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Stage 0: take magnitudes and work out the special cases.
  rv32m_op_e            op;
  logic                 an, bn, sa, sb;
  logic [DataWidth-1:0] ma, mb;
  assign op = rv32m_op_e'(req.req_type);
  assign an = req.operand_a[DataWidth-1];
  assign bn = req.operand_b[DataWidth-1];

  always_comb begin
    sa = 1'b0;
    sb = 1'b0;
    unique case (op)
      OP_MULH:           begin sa = an; sb = bn; end
      OP_MULHSU:         sa = an;
      OP_DIV, OP_REM:    begin sa = an; sb = bn; end
      default:           ;
    endcase
    ma = sa ? DataWidth'(-req.operand_a) : req.operand_a;
    mb = sb ? DataWidth'(-req.operand_b) : req.operand_b;
  end

  rv32m_ctl_t             c0_d, c0_q, c0_in;
  logic                   vld0_q;
  logic [DataWidth-1:0]   x0_q, y0_q, a0_q;
  logic                   zero0_q, ovf0_q, rem0_q;
  logic [2*DataWidth-1:0] acc0_q;

  always_comb begin
    c0_d.valid   = req.valid;
    c0_d.op      = op;
    c0_d.is_div  = req.req_type[2];
    c0_d.neg_res = (op == OP_REM) ? sa : (sa ^ sb);
    c0_d.dest    = req.dest_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= c0_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q    <= c0_d;
      x0_q    <= ma;
      y0_q    <= mb;
      acc0_q  <= req.req_type[2] ? {{DataWidth{1'b0}}, ma} : '0;
      a0_q    <= req.operand_a;
      zero0_q <= (req.operand_b == '0);
      ovf0_q  <= (op == OP_DIV || op == OP_REM) && req.operand_a == MinNeg &&
                 req.operand_b == AllOnes;
      rem0_q  <= req.req_type[1];
    end
  end

  always_comb begin
    c0_in       = c0_q;
    c0_in.valid = vld0_q;
  end

  // Side info for special cases rides a delay line alongside the chain.
  logic [DataWidth-1:0] a_dl   [DataWidth];
  logic                 z_dl   [DataWidth];
  logic                 o_dl   [DataWidth];
  logic                 r_dl   [DataWidth];

  for (genvar g = 0; g < DataWidth; g++) begin : g_dl
    always_ff @(posedge clk_i) begin
      if (en) begin
        a_dl[g] <= (g == 0) ? a0_q    : a_dl[(g == 0) ? 0 : g-1];
        z_dl[g] <= (g == 0) ? zero0_q : z_dl[(g == 0) ? 0 : g-1];
        o_dl[g] <= (g == 0) ? ovf0_q  : o_dl[(g == 0) ? 0 : g-1];
        r_dl[g] <= (g == 0) ? rem0_q  : r_dl[(g == 0) ? 0 : g-1];
      end
    end
  end

  rv32m_ctl_t             cn;
  logic [2*DataWidth-1:0] accn;

  rv32m_chain #(.DataWidth(DataWidth)) u_chain (
    .clk_i, .rst_ni, .en_i(en),
    .ctl_i(c0_in), .acc_i(acc0_q), .x_i(x0_q), .y_i(y0_q),
    .ctl_o(cn), .acc_o(accn)
  );

  // Final stage: sign fixup and special-case selection.
  logic [2*DataWidth-1:0] prod;
  logic [DataWidth-1:0]   raw, res;
  logic                   z, o, rm;
  assign z  = z_dl[DataWidth-1];
  assign o  = o_dl[DataWidth-1];
  assign rm = r_dl[DataWidth-1];

  always_comb begin
    prod = cn.neg_res ? (2*DataWidth)'(-accn) : accn;
    if (cn.is_div) begin
      raw = rm ? accn[2*DataWidth-1:DataWidth] : accn[DataWidth-1:0];
      raw = cn.neg_res ? DataWidth'(-raw) : raw;
      if (z) begin
        res = rm ? a_dl[DataWidth-1] : AllOnes;
      end else if (o) begin
        res = rm ? '0 : a_dl[DataWidth-1];
      end else begin
        res = raw;
      end
    end else begin
      raw = prod[DataWidth-1:0];
      res = (cn.op == OP_MUL) ? prod[DataWidth-1:0] : prod[2*DataWidth-1:DataWidth];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= cn.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp.result_value <= res;
      rsp.result_dest  <= cn.dest;
    end
  end
endmodule

// ===== rtl/core/rv32m_checker.sv =====
// Port-level checker for the multiply/divide unit, bound to the top level.
module rv32m_checker
  import rv32m_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [DataWidth-1:0] rsp_value
);
  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
    else $error("result changed while stalled");

  // Input is stalled exactly when output is stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("ready does not follow output side");

  // Request valid/ready and result valid stay known out of reset.
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({req_valid, req_ready, rsp_valid}))
    else $error("handshake signal unknown");
endmodule

bind rv32m_multiply_divide_unit_top rv32m_checker #(.DataWidth(DataWidth)) u_checker (
  .clk_i, .rst_ni,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_value(rsp.result_value)
);
